### src/qtp_pkg.sv
// Package for the quad-tree 4D box pruner: quadrant masks, strategy and register codes,
// and the structs shared by the front, the queue users and the back.
// No dependencies.
package qtp_pkg;

   localparam int QUADRANTS = 16;
   localparam int QUAD_BITS = $clog2(QUADRANTS);
   localparam logic [QUAD_BITS-1:0] LAST_QUAD = QUAD_BITS'(QUADRANTS - 1);

   localparam logic [QUAD_BITS-1:0] QUAD_LOW_X  = 4'h8;
   localparam logic [QUAD_BITS-1:0] QUAD_HIGH_X = 4'h4;
   localparam logic [QUAD_BITS-1:0] QUAD_LOW_Y  = 4'h2;
   localparam logic [QUAD_BITS-1:0] QUAD_HIGH_Y = 4'h1;

   localparam int STRAT_BITS = 4;
   localparam logic [STRAT_BITS-1:0] STRAT_OVERLAP      = 4'd0;
   localparam logic [STRAT_BITS-1:0] STRAT_CONTAINED_BY = 4'd1;
   localparam logic [STRAT_BITS-1:0] STRAT_CONTAINS     = 4'd2;
   localparam logic [STRAT_BITS-1:0] STRAT_SAME         = 4'd3;
   localparam logic [STRAT_BITS-1:0] STRAT_LEFT         = 4'd4;
   localparam logic [STRAT_BITS-1:0] STRAT_OVERLEFT     = 4'd5;
   localparam logic [STRAT_BITS-1:0] STRAT_RIGHT        = 4'd6;
   localparam logic [STRAT_BITS-1:0] STRAT_OVERRIGHT    = 4'd7;
   localparam logic [STRAT_BITS-1:0] STRAT_BEFORE       = 4'd8;
   localparam logic [STRAT_BITS-1:0] STRAT_OVERBEFORE   = 4'd9;
   localparam logic [STRAT_BITS-1:0] STRAT_AFTER        = 4'd10;
   localparam logic [STRAT_BITS-1:0] STRAT_OVERAFTER    = 4'd11;

   localparam int CSR_INDEX_BITS = 3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_STRATEGY     = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_QUERY_LOW_X  = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_QUERY_HIGH_X = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_QUERY_LOW_Y  = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_QUERY_HIGH_Y = 3'd4;

   // Comparisons of a lower-corner coordinate against the query.
   typedef struct packed {
      logic le_qh;
      logic le_ql;
      logic lt_ql;
   } low_flags_type;

   // Comparisons of an upper-corner coordinate against the query.
   typedef struct packed {
      logic ge_ql;
      logic ge_qh;
      logic gt_qh;
   } high_flags_type;

   typedef struct packed {
      low_flags_type  p_lx;
      low_flags_type  c_lx;
      low_flags_type  p_ly;
      low_flags_type  c_ly;
      high_flags_type p_hx;
      high_flags_type c_hx;
      high_flags_type p_hy;
      high_flags_type c_hy;
   } node_flags_type;

   typedef struct packed {
      logic [STRAT_BITS-1:0] strategy;
      logic                  x_absent;
      logic                  y_absent;
   } prune_ctrl_type;

endpackage

### src/qtp_front.sv
// Front stage of the pruner: accepts a node item, narrows its coordinates and
// classifies each candidate bound against the query box. Depends on qtp_pkg.
module qtp_front import qtp_pkg::*; #(
   parameter int COORD_BITS = 64,
   localparam int NODE_BITS = 12 * COORD_BITS + $bits(node_flags_type)
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic signed [63:0]           req_parent_left_low_x,
   input  logic signed [63:0]           req_parent_left_high_x,
   input  logic signed [63:0]           req_parent_left_low_y,
   input  logic signed [63:0]           req_parent_left_high_y,
   input  logic signed [63:0]           req_parent_right_low_x,
   input  logic signed [63:0]           req_parent_right_high_x,
   input  logic signed [63:0]           req_parent_right_low_y,
   input  logic signed [63:0]           req_parent_right_high_y,
   input  logic signed [63:0]           req_center_low_x,
   input  logic signed [63:0]           req_center_high_x,
   input  logic signed [63:0]           req_center_low_y,
   input  logic signed [63:0]           req_center_high_y,
   input  logic signed [COORD_BITS-1:0] q_low_x,
   input  logic signed [COORD_BITS-1:0] q_high_x,
   input  logic signed [COORD_BITS-1:0] q_low_y,
   input  logic signed [COORD_BITS-1:0] q_high_y,
   output logic                         push_valid,
   input  logic                         push_ready,
   output logic [NODE_BITS-1:0]         push_data
);

   typedef logic signed [COORD_BITS-1:0] coord_type;

   typedef struct packed {
      logic [7:0][COORD_BITS-1:0] parent;
      logic [3:0][COORD_BITS-1:0] center;
      node_flags_type             flags;
   } node_type;

   coord_type p [8];
   coord_type c [4];
   node_type  node_in, node_ff;
   logic      in_valid_in, in_valid_ff;
   logic      accept;

   assign p[0] = coord_type'(req_parent_left_low_x[COORD_BITS-1:0]);
   assign p[1] = coord_type'(req_parent_left_high_x[COORD_BITS-1:0]);
   assign p[2] = coord_type'(req_parent_left_low_y[COORD_BITS-1:0]);
   assign p[3] = coord_type'(req_parent_left_high_y[COORD_BITS-1:0]);
   assign p[4] = coord_type'(req_parent_right_low_x[COORD_BITS-1:0]);
   assign p[5] = coord_type'(req_parent_right_high_x[COORD_BITS-1:0]);
   assign p[6] = coord_type'(req_parent_right_low_y[COORD_BITS-1:0]);
   assign p[7] = coord_type'(req_parent_right_high_y[COORD_BITS-1:0]);
   assign c[0] = coord_type'(req_center_low_x[COORD_BITS-1:0]);
   assign c[1] = coord_type'(req_center_high_x[COORD_BITS-1:0]);
   assign c[2] = coord_type'(req_center_low_y[COORD_BITS-1:0]);
   assign c[3] = coord_type'(req_center_high_y[COORD_BITS-1:0]);

   always_comb begin
      for (int i = 0; i < 8; i++) begin
         node_in.parent[i] = p[i];
      end
      for (int i = 0; i < 4; i++) begin
         node_in.center[i] = c[i];
      end
      node_in.flags.p_lx.le_qh = p[0] <= q_high_x;
      node_in.flags.p_lx.le_ql = p[0] <= q_low_x;
      node_in.flags.p_lx.lt_ql = p[0] <  q_low_x;
      node_in.flags.c_lx.le_qh = c[0] <= q_high_x;
      node_in.flags.c_lx.le_ql = c[0] <= q_low_x;
      node_in.flags.c_lx.lt_ql = c[0] <  q_low_x;
      node_in.flags.p_ly.le_qh = p[2] <= q_high_y;
      node_in.flags.p_ly.le_ql = p[2] <= q_low_y;
      node_in.flags.p_ly.lt_ql = p[2] <  q_low_y;
      node_in.flags.c_ly.le_qh = c[2] <= q_high_y;
      node_in.flags.c_ly.le_ql = c[2] <= q_low_y;
      node_in.flags.c_ly.lt_ql = c[2] <  q_low_y;
      node_in.flags.p_hx.ge_ql = p[5] >= q_low_x;
      node_in.flags.p_hx.ge_qh = p[5] >= q_high_x;
      node_in.flags.p_hx.gt_qh = p[5] >  q_high_x;
      node_in.flags.c_hx.ge_ql = c[1] >= q_low_x;
      node_in.flags.c_hx.ge_qh = c[1] >= q_high_x;
      node_in.flags.c_hx.gt_qh = c[1] >  q_high_x;
      node_in.flags.p_hy.ge_ql = p[7] >= q_low_y;
      node_in.flags.p_hy.ge_qh = p[7] >= q_high_y;
      node_in.flags.p_hy.gt_qh = p[7] >  q_high_y;
      node_in.flags.c_hy.ge_ql = c[3] >= q_low_y;
      node_in.flags.c_hy.ge_qh = c[3] >= q_high_y;
      node_in.flags.c_hy.gt_qh = c[3] >  q_high_y;
   end

   assign req_ready  = !in_valid_ff || push_ready;
   assign accept     = req_valid && req_ready;
   assign push_valid = in_valid_ff;
   assign push_data  = node_ff;

   always_comb begin
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (push_ready) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         node_ff <= node_in;
      end
   end

endmodule

### src/qtp_queue.sv
// Short node queue between the front and back stages of the pruner.
// Depends on no package.
module qtp_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_data
);

   localparam int PTR_BITS   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int COUNT_BITS = $clog2(DEPTH + 1);
   localparam logic [PTR_BITS-1:0]   LAST_PTR   = PTR_BITS'(DEPTH - 1);
   localparam logic [COUNT_BITS-1:0] FULL_COUNT = COUNT_BITS'(DEPTH);

   logic [WIDTH-1:0]      entry_ff [DEPTH];
   logic [PTR_BITS-1:0]   wr_ptr_in, wr_ptr_ff, rd_ptr_in, rd_ptr_ff;
   logic [COUNT_BITS-1:0] count_in, count_ff;
   logic                  push, pop;

   assign push_ready = count_ff != FULL_COUNT;
   assign pop_valid  = count_ff != '0;
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_COUNT)
      else $error("queue count exceeds its depth");

endmodule

### src/qtp_back.sv
// Back stage of the pruner: walks the sixteen quadrants of the node at the queue
// head, one per cycle unless rsp_ready stalls it, into the result register. Depends on qtp_pkg.
module qtp_back import qtp_pkg::*; #(
   parameter int COORD_BITS = 64,
   localparam int NODE_BITS = 12 * COORD_BITS + $bits(node_flags_type)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  prune_ctrl_type        ctrl,
   input  logic                  head_valid,
   output logic                  head_pop,
   input  logic [NODE_BITS-1:0]  head_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [3:0]            rsp_quadrant_index,
   output logic                  rsp_visit,
   output logic signed [63:0]    rsp_child_left_low_x,
   output logic signed [63:0]    rsp_child_left_high_x,
   output logic signed [63:0]    rsp_child_left_low_y,
   output logic signed [63:0]    rsp_child_left_high_y,
   output logic signed [63:0]    rsp_child_right_low_x,
   output logic signed [63:0]    rsp_child_right_high_x,
   output logic signed [63:0]    rsp_child_right_low_y,
   output logic signed [63:0]    rsp_child_right_high_y,
   output logic                  rsp_final_quadrant
);

   typedef logic signed [COORD_BITS-1:0] coord_type;

   typedef struct packed {
      logic [7:0][COORD_BITS-1:0] parent;
      logic [3:0][COORD_BITS-1:0] center;
      node_flags_type             flags;
   } node_type;

   node_type                   head;
   logic [QUAD_BITS-1:0]       cnt_in, cnt_ff;
   logic                       advance;
   logic                       bit_lx, bit_hx, bit_ly, bit_hy;
   low_flags_type              lo_x, lo_y;
   high_flags_type             hi_x, hi_y;
   logic                       visit;
   logic [7:0][COORD_BITS-1:0] child;
   logic                       rsp_valid_in, rsp_valid_ff;
   logic [QUAD_BITS-1:0]       rsp_quad_ff;
   logic                       rsp_visit_ff, rsp_final_ff;
   logic [7:0][COORD_BITS-1:0] child_ff;

   assign head     = head_data;
   assign advance  = head_valid && (!rsp_valid_ff || rsp_ready);
   assign head_pop = advance && (cnt_ff == LAST_QUAD);
   assign cnt_in   = advance ? ((cnt_ff == LAST_QUAD) ? '0 : cnt_ff + 1'b1) : cnt_ff;

   assign bit_lx = (cnt_ff & QUAD_LOW_X) != '0;
   assign bit_hx = (cnt_ff & QUAD_HIGH_X) != '0;
   assign bit_ly = (cnt_ff & QUAD_LOW_Y) != '0;
   assign bit_hy = (cnt_ff & QUAD_HIGH_Y) != '0;

   always_comb begin
      child    = head.parent;
      if (bit_lx) begin
         child[0] = head.center[0];
      end else begin
         child[1] = head.center[0];
      end
      if (bit_hx) begin
         child[4] = head.center[1];
      end else begin
         child[5] = head.center[1];
      end
      if (bit_ly) begin
         child[2] = head.center[2];
      end else begin
         child[3] = head.center[2];
      end
      if (bit_hy) begin
         child[6] = head.center[3];
      end else begin
         child[7] = head.center[3];
      end
   end

   assign lo_x = bit_lx ? head.flags.c_lx : head.flags.p_lx;
   assign hi_x = bit_hx ? head.flags.p_hx : head.flags.c_hx;
   assign lo_y = bit_ly ? head.flags.c_ly : head.flags.p_ly;
   assign hi_y = bit_hy ? head.flags.p_hy : head.flags.c_hy;

   always_comb begin
      case (ctrl.strategy)
         STRAT_OVERLAP, STRAT_CONTAINED_BY: begin
            visit = (ctrl.x_absent || (lo_x.le_qh && hi_x.ge_ql)) &&
                    (ctrl.y_absent || (lo_y.le_qh && hi_y.ge_ql));
         end
         STRAT_CONTAINS, STRAT_SAME: begin
            visit = (ctrl.x_absent || (hi_x.ge_qh && lo_x.le_ql)) &&
                    (ctrl.y_absent || (hi_y.ge_qh && lo_y.le_ql));
         end
         STRAT_LEFT:       visit = lo_x.lt_ql;
         STRAT_OVERLEFT:   visit = lo_x.le_qh;
         STRAT_RIGHT:      visit = hi_x.gt_qh;
         STRAT_OVERRIGHT:  visit = hi_x.ge_ql;
         STRAT_BEFORE:     visit = lo_y.lt_ql;
         STRAT_OVERBEFORE: visit = lo_y.le_qh;
         STRAT_AFTER:      visit = hi_y.gt_qh;
         STRAT_OVERAFTER:  visit = hi_y.ge_ql;
         default:          visit = 1'b1;
      endcase
   end

   always_comb begin
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_quad_ff  <= cnt_ff;
         rsp_visit_ff <= visit;
         rsp_final_ff <= cnt_ff == LAST_QUAD;
         child_ff     <= child;
      end
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_quadrant_index     = rsp_quad_ff;
   assign rsp_visit              = rsp_visit_ff;
   assign rsp_final_quadrant     = rsp_final_ff;
   assign rsp_child_left_low_x   = 64'(coord_type'(child_ff[0]));
   assign rsp_child_left_high_x  = 64'(coord_type'(child_ff[1]));
   assign rsp_child_left_low_y   = 64'(coord_type'(child_ff[2]));
   assign rsp_child_left_high_y  = 64'(coord_type'(child_ff[3]));
   assign rsp_child_right_low_x  = 64'(coord_type'(child_ff[4]));
   assign rsp_child_right_high_x = 64'(coord_type'(child_ff[5]));
   assign rsp_child_right_low_y  = 64'(coord_type'(child_ff[6]));
   assign rsp_child_right_high_y = 64'(coord_type'(child_ff[7]));

   a_node_held: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff != '0) |-> head_valid)
      else $error("node left the queue before all quadrants were sent");

   a_quad_sequence: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && advance) |=> (rsp_quad_ff == $past(rsp_quad_ff) + 1'b1))
      else $error("quadrant results out of order");

   a_final_matches: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_final_ff == (rsp_quad_ff == LAST_QUAD)))
      else $error("final flag does not match the quadrant index");

endmodule

### src/quad_tree_4d_box_pruner_core.sv
// Takes one inner node per item and returns sixteen items, one per quadrant in order
// 0 to 15, each with the narrowed child bounds and a visit flag from the query test
// under the configured strategy. Results leave at one per cycle while rsp_ready is
// high; a node holds the back stage for all sixteen, set by its quadrant counter and
// single result register. A node passes the front register, queue entry and result
// register. A front stage and a short queue take in following nodes while results
// stall. Configuration is to be written by the user only while idle; the block does
// not enforce it. Top level; depends on qtp_pkg, qtp_front, qtp_queue and qtp_back.
module quad_tree_4d_box_pruner_core import qtp_pkg::*; #(
   parameter int COORD_BITS  = 64,
   parameter int QUEUE_DEPTH = 2
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic signed [63:0]        req_parent_left_low_x,
   input  logic signed [63:0]        req_parent_left_high_x,
   input  logic signed [63:0]        req_parent_left_low_y,
   input  logic signed [63:0]        req_parent_left_high_y,
   input  logic signed [63:0]        req_parent_right_low_x,
   input  logic signed [63:0]        req_parent_right_high_x,
   input  logic signed [63:0]        req_parent_right_low_y,
   input  logic signed [63:0]        req_parent_right_high_y,
   input  logic signed [63:0]        req_center_low_x,
   input  logic signed [63:0]        req_center_high_x,
   input  logic signed [63:0]        req_center_low_y,
   input  logic signed [63:0]        req_center_high_y,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [3:0]                rsp_quadrant_index,
   output logic                      rsp_visit,
   output logic signed [63:0]        rsp_child_left_low_x,
   output logic signed [63:0]        rsp_child_left_high_x,
   output logic signed [63:0]        rsp_child_left_low_y,
   output logic signed [63:0]        rsp_child_left_high_y,
   output logic signed [63:0]        rsp_child_right_low_x,
   output logic signed [63:0]        rsp_child_right_high_x,
   output logic signed [63:0]        rsp_child_right_low_y,
   output logic signed [63:0]        rsp_child_right_high_y,
   output logic                      rsp_final_quadrant,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [63:0]               csr_data
);

   localparam int NODE_BITS = 12 * COORD_BITS + $bits(node_flags_type);

   typedef logic signed [COORD_BITS-1:0] coord_type;

   localparam coord_type PLUS_INF = {1'b0, {(COORD_BITS - 1){1'b1}}};

   logic [STRAT_BITS-1:0] strategy_in, strategy_ff;
   coord_type             q_low_x_in, q_low_x_ff, q_high_x_in, q_high_x_ff;
   coord_type             q_low_y_in, q_low_y_ff, q_high_y_in, q_high_y_ff;
   prune_ctrl_type        ctrl;
   logic                  push_valid, push_ready, head_valid, head_pop;
   logic [NODE_BITS-1:0]  push_data, head_data;

   assign csr_ready = 1'b1;

   always_comb begin
      strategy_in = strategy_ff;
      q_low_x_in  = q_low_x_ff;
      q_high_x_in = q_high_x_ff;
      q_low_y_in  = q_low_y_ff;
      q_high_y_in = q_high_y_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_STRATEGY:     strategy_in = csr_data[STRAT_BITS-1:0];
            CSR_QUERY_LOW_X:  q_low_x_in  = coord_type'(csr_data[COORD_BITS-1:0]);
            CSR_QUERY_HIGH_X: q_high_x_in = coord_type'(csr_data[COORD_BITS-1:0]);
            CSR_QUERY_LOW_Y:  q_low_y_in  = coord_type'(csr_data[COORD_BITS-1:0]);
            CSR_QUERY_HIGH_Y: q_high_y_in = coord_type'(csr_data[COORD_BITS-1:0]);
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strategy_ff <= '0;
         q_low_x_ff  <= '0;
         q_high_x_ff <= '0;
         q_low_y_ff  <= '0;
         q_high_y_ff <= '0;
      end else begin
         strategy_ff <= strategy_in;
         q_low_x_ff  <= q_low_x_in;
         q_high_x_ff <= q_high_x_in;
         q_low_y_ff  <= q_low_y_in;
         q_high_y_ff <= q_high_y_in;
      end
   end

   assign ctrl.strategy = strategy_ff;
   assign ctrl.x_absent = q_high_x_ff == PLUS_INF;
   assign ctrl.y_absent = q_high_y_ff == PLUS_INF;

   qtp_front #(
      .COORD_BITS(COORD_BITS)
   ) u_front (
      .clock                   (clock),
      .reset                   (reset),
      .req_valid               (req_valid),
      .req_ready               (req_ready),
      .req_parent_left_low_x   (req_parent_left_low_x),
      .req_parent_left_high_x  (req_parent_left_high_x),
      .req_parent_left_low_y   (req_parent_left_low_y),
      .req_parent_left_high_y  (req_parent_left_high_y),
      .req_parent_right_low_x  (req_parent_right_low_x),
      .req_parent_right_high_x (req_parent_right_high_x),
      .req_parent_right_low_y  (req_parent_right_low_y),
      .req_parent_right_high_y (req_parent_right_high_y),
      .req_center_low_x        (req_center_low_x),
      .req_center_high_x       (req_center_high_x),
      .req_center_low_y        (req_center_low_y),
      .req_center_high_y       (req_center_high_y),
      .q_low_x                 (q_low_x_ff),
      .q_high_x                (q_high_x_ff),
      .q_low_y                 (q_low_y_ff),
      .q_high_y                (q_high_y_ff),
      .push_valid              (push_valid),
      .push_ready              (push_ready),
      .push_data               (push_data)
   );

   qtp_queue #(
      .WIDTH(NODE_BITS),
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (head_valid),
      .pop_ready  (head_pop),
      .pop_data   (head_data)
   );

   qtp_back #(
      .COORD_BITS(COORD_BITS)
   ) u_back (
      .clock                  (clock),
      .reset                  (reset),
      .ctrl                   (ctrl),
      .head_valid             (head_valid),
      .head_pop               (head_pop),
      .head_data              (head_data),
      .rsp_valid              (rsp_valid),
      .rsp_ready              (rsp_ready),
      .rsp_quadrant_index     (rsp_quadrant_index),
      .rsp_visit              (rsp_visit),
      .rsp_child_left_low_x   (rsp_child_left_low_x),
      .rsp_child_left_high_x  (rsp_child_left_high_x),
      .rsp_child_left_low_y   (rsp_child_left_low_y),
      .rsp_child_left_high_y  (rsp_child_left_high_y),
      .rsp_child_right_low_x  (rsp_child_right_low_x),
      .rsp_child_right_high_x (rsp_child_right_high_x),
      .rsp_child_right_low_y  (rsp_child_right_low_y),
      .rsp_child_right_high_y (rsp_child_right_high_y),
      .rsp_final_quadrant     (rsp_final_quadrant)
   );

endmodule
